// ----- sv/tksd_pkg.sv -----
// Shared types, key codes and lookup functions for the terminal key sequence decoder.
`timescale 1ns / 1ps

package tksd_pkg;

  // Key codes carried on the key field of a result word.
  localparam logic [4:0] KEY_NONE      = 5'd0;
  localparam logic [4:0] KEY_CHAR      = 5'd1;
  localparam logic [4:0] KEY_ENTER     = 5'd2;
  localparam logic [4:0] KEY_TAB       = 5'd3;
  localparam logic [4:0] KEY_BACKSPACE = 5'd4;
  localparam logic [4:0] KEY_ESCAPE    = 5'd5;
  localparam logic [4:0] KEY_UP        = 5'd6;
  localparam logic [4:0] KEY_DOWN      = 5'd7;
  localparam logic [4:0] KEY_RIGHT     = 5'd8;
  localparam logic [4:0] KEY_LEFT      = 5'd9;
  localparam logic [4:0] KEY_HOME      = 5'd10;
  localparam logic [4:0] KEY_END       = 5'd11;
  localparam logic [4:0] KEY_INSERT    = 5'd12;
  localparam logic [4:0] KEY_DELETE    = 5'd13;
  localparam logic [4:0] KEY_PGUP      = 5'd14;
  localparam logic [4:0] KEY_PGDN      = 5'd15;
  localparam logic [4:0] KEY_F1        = 5'd16;
  localparam logic [4:0] KEY_F2        = 5'd17;
  localparam logic [4:0] KEY_F3        = 5'd18;
  localparam logic [4:0] KEY_F4        = 5'd19;
  localparam logic [4:0] KEY_F5        = 5'd20;
  localparam logic [4:0] KEY_F6        = 5'd21;
  localparam logic [4:0] KEY_F7        = 5'd22;
  localparam logic [4:0] KEY_F8        = 5'd23;
  localparam logic [4:0] KEY_F9        = 5'd24;
  localparam logic [4:0] KEY_F10       = 5'd25;
  localparam logic [4:0] KEY_F11       = 5'd26;
  localparam logic [4:0] KEY_F12       = 5'd27;

  // Bytes with a special meaning.
  localparam logic [7:0] BYTE_ESC       = 8'd27;
  localparam logic [7:0] BYTE_CONT_MASK = 8'hC0;
  localparam logic [7:0] BYTE_CONT_VAL  = 8'h80;
  localparam logic [7:0] BYTE_LEAD2_VAL = 8'hC0;
  localparam logic [7:0] BYTE_LEAD3_VAL = 8'hE0;
  localparam logic [7:0] BYTE_LEAD4_VAL = 8'hF0;
  localparam logic [7:0] BYTE_LEAD2_MSK = 8'hE0;
  localparam logic [7:0] BYTE_LEAD3_MSK = 8'hF0;
  localparam logic [7:0] BYTE_LEAD4_MSK = 8'hF8;
  localparam logic [7:0] CHAR_A_LESS1   = 8'd96;
  localparam logic [7:0] SAT_PARAM      = 8'd255;
  localparam logic [7:0] TILDE_LAST     = 8'd24;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_UTF8 = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_CSI  = 3'd3,
    MODE_SS3  = 3'd4
  } tksd_mode_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } tksd_in_t;

  typedef struct packed {
    logic [4:0]  key;
    logic [20:0] code_point;
    logic        ctrl_mod;
    logic        alt_mod;
    logic        shift_mod;
  } tksd_out_t;

  // A classified input word, as the front hands it to the parser.
  typedef struct packed {
    logic       timeout;
    logic [7:0] data_byte;
    logic       is_esc;
    logic       is_digit;
    logic       is_semi;
    logic       is_cont;
    logic       is_csi_intro;
    logic       is_ss3_intro;
    logic       csi_z;
    logic       csi_tilde;
    logic [4:0] csi_key;
    logic [4:0] ss3_key;
    logic [1:0] lead_len;
    logic [4:0] lead_cp;
    logic [4:0] idle_key;
    logic [7:0] idle_cp;
    logic       idle_ctrl;
  } tksd_tok_t;

  // Parser status seen by the top level.
  typedef struct packed {
    logic tok_pop;
    logic res_push;
    logic idle;
  } tksd_stat_t;

  function automatic logic [4:0] tilde_key(input logic [4:0] p);
    logic [4:0] k;
    case (p)
      5'd1, 5'd7: k = KEY_HOME;
      5'd2:       k = KEY_INSERT;
      5'd3:       k = KEY_DELETE;
      5'd4, 5'd8: k = KEY_END;
      5'd5:       k = KEY_PGUP;
      5'd6:       k = KEY_PGDN;
      5'd11:      k = KEY_F1;
      5'd12:      k = KEY_F2;
      5'd13:      k = KEY_F3;
      5'd14:      k = KEY_F4;
      5'd15:      k = KEY_F5;
      5'd17:      k = KEY_F6;
      5'd18:      k = KEY_F7;
      5'd19:      k = KEY_F8;
      5'd20:      k = KEY_F9;
      5'd21:      k = KEY_F10;
      5'd23:      k = KEY_F11;
      5'd24:      k = KEY_F12;
      default:    k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] ss3_key(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      "P":     k = KEY_F1;
      "Q":     k = KEY_F2;
      "R":     k = KEY_F3;
      "S":     k = KEY_F4;
      "H":     k = KEY_HOME;
      "F":     k = KEY_END;
      "A":     k = KEY_UP;
      "B":     k = KEY_DOWN;
      "C":     k = KEY_RIGHT;
      "D":     k = KEY_LEFT;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] csi_letter_key(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      "A":     k = KEY_UP;
      "B":     k = KEY_DOWN;
      "C":     k = KEY_RIGHT;
      "D":     k = KEY_LEFT;
      "H":     k = KEY_HOME;
      "F":     k = KEY_END;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/tksd_fifo.sv -----
// Small register-based queue with simultaneous push and pop.
`timescale 1ns / 1ps

module tksd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/tksd_front.sv -----
// Front end: accepts input words and classifies each byte for the parser.
`timescale 1ns / 1ps

module tksd_front (
  input  logic                push_i,
  input  tksd_pkg::tksd_in_t  word_i,
  input  logic                tok_full_i,
  output logic                tok_push_o,
  output tksd_pkg::tksd_tok_t tok_o
);

  logic [7:0] b;

  assign b          = word_i.data_byte;
  assign tok_push_o = push_i & ~tok_full_i;

  always_comb begin
    tok_o              = '0;
    tok_o.timeout      = word_i.op;
    tok_o.data_byte    = b;
    tok_o.is_esc       = (b == tksd_pkg::BYTE_ESC);
    tok_o.is_digit     = (b >= "0") && (b <= "9");
    tok_o.is_semi      = (b == ";");
    tok_o.is_cont      = ((b & tksd_pkg::BYTE_CONT_MASK) == tksd_pkg::BYTE_CONT_VAL);
    tok_o.is_csi_intro = (b == "[");
    tok_o.is_ss3_intro = (b == "O");
    tok_o.csi_z        = (b == "Z");
    tok_o.csi_tilde    = (b == "~");
    tok_o.csi_key      = tksd_pkg::csi_letter_key(b);
    tok_o.ss3_key      = tksd_pkg::ss3_key(b);

    // What the byte means when no sequence is open. A UTF-8 lead byte
    // opens a sequence and gives no result of its own.
    tok_o.lead_len  = 2'd0;
    tok_o.lead_cp   = 5'd0;
    tok_o.idle_key  = tksd_pkg::KEY_CHAR;
    tok_o.idle_cp   = 8'd0;
    tok_o.idle_ctrl = 1'b0;
    if (b == 8'd13 || b == 8'd10) begin
      tok_o.idle_key = tksd_pkg::KEY_ENTER;
    end else if (b == 8'd9) begin
      tok_o.idle_key = tksd_pkg::KEY_TAB;
    end else if (b == 8'd127 || b == 8'd8) begin
      tok_o.idle_key = tksd_pkg::KEY_BACKSPACE;
    end else if (b >= 8'd1 && b <= 8'd26) begin
      tok_o.idle_cp   = tksd_pkg::CHAR_A_LESS1 + b;
      tok_o.idle_ctrl = 1'b1;
    end else if (!b[7]) begin
      tok_o.idle_cp = b;
    end else if ((b & tksd_pkg::BYTE_LEAD2_MSK) == tksd_pkg::BYTE_LEAD2_VAL) begin
      tok_o.lead_len = 2'd1;
      tok_o.lead_cp  = b[4:0];
    end else if ((b & tksd_pkg::BYTE_LEAD3_MSK) == tksd_pkg::BYTE_LEAD3_VAL) begin
      tok_o.lead_len = 2'd2;
      tok_o.lead_cp  = {1'b0, b[3:0]};
    end else if ((b & tksd_pkg::BYTE_LEAD4_MSK) == tksd_pkg::BYTE_LEAD4_VAL) begin
      tok_o.lead_len = 2'd3;
      tok_o.lead_cp  = {2'b0, b[2:0]};
    end else begin
      tok_o.idle_cp = b;
    end
  end

endmodule

// ----- sv/tksd_back.sv -----
// Back end: the sequence parser that turns classified words into key results.
`timescale 1ns / 1ps

module tksd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tksd_pkg::tksd_tok_t tok_i,
  input  logic                tok_empty_i,
  input  logic                res_full_i,
  output tksd_pkg::tksd_out_t res_o,
  output tksd_pkg::tksd_stat_t stat_o
);

  tksd_pkg::tksd_mode_e mode_q, mode_d;
  logic [1:0]  left_q, left_d;
  logic [20:0] cp_q, cp_d;
  logic [7:0]  lead_q, lead_d;
  logic [7:0]  p1_q, p1_d;
  logic [2:0]  p2_q, p2_d;
  logic [1:0]  sep_q, sep_d;

  logic        take;
  logic        emit;
  logic [20:0] cp_next;
  logic [11:0] p1_acc;
  logic [2:0]  mods;

  assign take    = ~tok_empty_i & ~res_full_i;
  assign cp_next = {cp_q[14:0], tok_i.data_byte[5:0]};
  assign p1_acc  = {1'b0, p1_q, 3'b0} + {3'b0, p1_q, 1'b0} + {8'b0, tok_i.data_byte[3:0]};
  // Modifier bits are the second parameter less one, modulo eight.
  assign mods    = p2_q - 3'd1;

  always_comb begin
    mode_d = mode_q;
    left_d = left_q;
    cp_d   = cp_q;
    lead_d = lead_q;
    p1_d   = p1_q;
    p2_d   = p2_q;
    sep_d  = sep_q;
    emit   = 1'b0;
    res_o  = '0;
    if (take) begin
      case (mode_q)
        tksd_pkg::MODE_UTF8: begin
          if (tok_i.timeout || !tok_i.is_cont) begin
            // A broken sequence is reported as its lead byte.
            mode_d           = tksd_pkg::MODE_IDLE;
            emit             = 1'b1;
            res_o.key        = tksd_pkg::KEY_CHAR;
            res_o.code_point = {13'b0, lead_q};
          end else begin
            cp_d   = cp_next;
            left_d = left_q - 2'd1;
            if (left_q == 2'd1) begin
              mode_d           = tksd_pkg::MODE_IDLE;
              emit             = 1'b1;
              res_o.key        = tksd_pkg::KEY_CHAR;
              res_o.code_point = cp_next;
            end
          end
        end
        tksd_pkg::MODE_ESC: begin
          if (tok_i.timeout) begin
            mode_d    = tksd_pkg::MODE_IDLE;
            emit      = 1'b1;
            res_o.key = tksd_pkg::KEY_ESCAPE;
          end else if (tok_i.is_csi_intro) begin
            mode_d = tksd_pkg::MODE_CSI;
            p1_d   = 8'd0;
            p2_d   = 3'd0;
            sep_d  = 2'd0;
          end else if (tok_i.is_ss3_intro) begin
            mode_d = tksd_pkg::MODE_SS3;
          end else begin
            mode_d           = tksd_pkg::MODE_IDLE;
            emit             = 1'b1;
            res_o.key        = tksd_pkg::KEY_CHAR;
            res_o.code_point = {13'b0, tok_i.data_byte};
            res_o.alt_mod    = 1'b1;
          end
        end
        tksd_pkg::MODE_CSI: begin
          if (tok_i.timeout) begin
            mode_d    = tksd_pkg::MODE_IDLE;
            emit      = 1'b1;
            res_o.key = tksd_pkg::KEY_ESCAPE;
          end else if (tok_i.is_digit) begin
            if (sep_q == 2'd0) begin
              p1_d = (p1_acc > {4'b0, tksd_pkg::SAT_PARAM}) ? tksd_pkg::SAT_PARAM
                                                             : p1_acc[7:0];
            end else if (sep_q == 2'd1) begin
              p2_d = {p2_q[1:0], 1'b0} + tok_i.data_byte[2:0];
            end
          end else if (tok_i.is_semi) begin
            if (sep_q != 2'd2) begin
              sep_d = sep_q + 2'd1;
            end
          end else begin
            mode_d = tksd_pkg::MODE_IDLE;
            emit   = 1'b1;
            if (sep_q != 2'd0) begin
              res_o.shift_mod = mods[0];
              res_o.alt_mod   = mods[1];
              res_o.ctrl_mod  = mods[2];
            end
            if (tok_i.csi_z) begin
              res_o.key       = tksd_pkg::KEY_TAB;
              res_o.shift_mod = 1'b1;
            end else if (tok_i.csi_tilde) begin
              res_o.key = (p1_q <= tksd_pkg::TILDE_LAST) ? tksd_pkg::tilde_key(p1_q[4:0])
                                                          : tksd_pkg::KEY_NONE;
            end else begin
              res_o.key = tok_i.csi_key;
            end
          end
        end
        tksd_pkg::MODE_SS3: begin
          mode_d    = tksd_pkg::MODE_IDLE;
          emit      = 1'b1;
          res_o.key = tok_i.timeout ? tksd_pkg::KEY_ESCAPE : tok_i.ss3_key;
        end
        default: begin
          mode_d = tksd_pkg::MODE_IDLE;
          if (!tok_i.timeout) begin
            if (tok_i.is_esc) begin
              mode_d = tksd_pkg::MODE_ESC;
            end else if (tok_i.lead_len != 2'd0) begin
              mode_d = tksd_pkg::MODE_UTF8;
              left_d = tok_i.lead_len;
              cp_d   = {16'b0, tok_i.lead_cp};
              lead_d = tok_i.data_byte;
            end else begin
              emit             = 1'b1;
              res_o.key        = tok_i.idle_key;
              res_o.code_point = {13'b0, tok_i.idle_cp};
              res_o.ctrl_mod   = tok_i.idle_ctrl;
            end
          end
        end
      endcase
    end
    stat_o.tok_pop  = take;
    stat_o.res_push = emit;
    stat_o.idle     = (mode_q != tksd_pkg::MODE_UTF8) && (mode_q != tksd_pkg::MODE_ESC) &&
                      (mode_q != tksd_pkg::MODE_CSI) && (mode_q != tksd_pkg::MODE_SS3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tksd_pkg::MODE_IDLE;
      left_q <= 2'd0;
      cp_q   <= 21'd0;
      lead_q <= 8'd0;
      p1_q   <= 8'd0;
      p2_q   <= 3'd0;
      sep_q  <= 2'd0;
    end else begin
      mode_q <= mode_d;
      left_q <= left_d;
      cp_q   <= cp_d;
      lead_q <= lead_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      sep_q  <= sep_d;
    end
  end

endmodule

// ----- sv/terminal_key_sequence_decoder.sv -----
// Top level of the terminal key sequence decoder: front, word queue, parser, result queue.
// Accepted words are registered in the word queue and results in the result queue.
// Throughput: one input word per cycle while neither queue is full.
// Words that end a sequence give one result; others give none.
// Reset (rst_ni low, asynchronous) empties both queues and returns the parser to idle.
`timescale 1ns / 1ps

module terminal_key_sequence_decoder #(
  parameter int unsigned TokDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  tksd_pkg::tksd_in_t  in_word_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output tksd_pkg::tksd_out_t out_word_o
);

  localparam int unsigned TokW = $bits(tksd_pkg::tksd_tok_t);
  localparam int unsigned ResW = $bits(tksd_pkg::tksd_out_t);

  tksd_pkg::tksd_tok_t  tok_in, tok_out;
  tksd_pkg::tksd_out_t  res_in;
  tksd_pkg::tksd_stat_t stat;
  logic                 tok_push, tok_full, tok_empty, res_full;

  tksd_front u_front (
    .push_i     (push),
    .word_i     (in_word_i),
    .tok_full_i (tok_full),
    .tok_push_o (tok_push),
    .tok_o      (tok_in)
  );

  tksd_fifo #(
    .Width (TokW),
    .Depth (TokDepth)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .full_o  (tok_full),
    .pop_i   (stat.tok_pop),
    .data_o  (tok_out),
    .empty_o (tok_empty)
  );

  tksd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_out),
    .tok_empty_i (tok_empty),
    .res_full_i  (res_full),
    .res_o       (res_in),
    .stat_o      (stat)
  );

  tksd_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stat.res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_word_o),
    .empty_o (empty)
  );

  assign full = tok_full;

`ifndef SYNTHESIS
  // A result is only produced while a word is consumed.
  a_push_needs_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_push |-> stat.tok_pop)
    else $error("result pushed without consuming a word");

  // The parser never consumes a word while the result queue is full.
  a_no_pop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_full |-> !stat.tok_pop)
    else $error("word consumed while result queue full");

  // A timeout with no open sequence gives nothing.
  a_idle_timeout_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.idle && stat.tok_pop && tok_out.timeout) |-> !stat.res_push)
    else $error("idle timeout produced a result");

  // Non-character keys never carry a code point.
  a_cp_only_for_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.res_push && res_in.key != tksd_pkg::KEY_CHAR) |-> (res_in.code_point == '0))
    else $error("code point on a non-character key");
`endif

endmodule

// ----- tb/tksd_key_checker.sv -----
// Key event checker for the terminal key sequence decoder: predicts and compares result words.
`timescale 1ns / 1ps

module tksd_key_checker
  import tksd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic      full_i,
  input  tksd_in_t  word_i,
  input  logic      empty_i,
  input  logic      pop_i,
  input  tksd_out_t key_i,
  output int        fail_count_o,
  output int        pending_o
);

  // Decoder state as the byte stream drives it.
  tksd_mode_e  mode_q;
  logic [1:0]  left_q;
  logic [20:0] cp_q;
  logic [7:0]  lead_q;
  logic [7:0]  p1_q;
  logic [2:0]  p2_q;
  logic [1:0]  semis_q;

  tksd_out_t   keys_due[$];
  tksd_out_t   want;
  tksd_out_t   made;
  bit          made_one;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic [4:0] tilde_key_of(input logic [7:0] p);
    logic [4:0] k;
    k = KEY_NONE;
    if (p == 8'd1 || p == 8'd7) k = KEY_HOME;
    else if (p == 8'd4 || p == 8'd8) k = KEY_END;
    else if (p == 8'd2) k = KEY_INSERT;
    else if (p == 8'd3) k = KEY_DELETE;
    else if (p == 8'd5) k = KEY_PGUP;
    else if (p == 8'd6) k = KEY_PGDN;
    else if (p >= 8'd11 && p <= 8'd15) k = KEY_F1 + 5'(p - 8'd11);
    else if (p >= 8'd17 && p <= 8'd21) k = KEY_F6 + 5'(p - 8'd17);
    else if (p == 8'd23) k = KEY_F11;
    else if (p == 8'd24) k = KEY_F12;
    return k;
  endfunction

  function automatic logic [4:0] cursor_key_of(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      "A": k = KEY_UP;
      "B": k = KEY_DOWN;
      "C": k = KEY_RIGHT;
      "D": k = KEY_LEFT;
      "H": k = KEY_HOME;
      "F": k = KEY_END;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] ss3_final_key(input logic [7:0] b);
    logic [4:0] k;
    if (b >= "P" && b <= "S") k = KEY_F1 + 5'(b - "P");
    else k = cursor_key_of(b);
    return k;
  endfunction

  task automatic decode_word(input tksd_in_t w, output bit hit, output tksd_out_t r);
    logic [7:0] b;
    logic [2:0] mods;
    int         acc;
    b   = w.data_byte;
    hit = 1'b0;
    r   = '0;
    case (mode_q)
      MODE_UTF8: begin
        if (w.op || b[7:6] != 2'b10) begin
          // A broken sequence gives its lead byte; the breaking byte is consumed.
          mode_q       = MODE_IDLE;
          hit          = 1'b1;
          r.key        = KEY_CHAR;
          r.code_point = {13'd0, lead_q};
        end else begin
          cp_q   = {cp_q[14:0], b[5:0]};
          left_q = left_q - 2'd1;
          if (left_q == 2'd0) begin
            mode_q       = MODE_IDLE;
            hit          = 1'b1;
            r.key        = KEY_CHAR;
            r.code_point = cp_q;
          end
        end
      end
      MODE_ESC: begin
        if (w.op) begin
          mode_q = MODE_IDLE;
          hit    = 1'b1;
          r.key  = KEY_ESCAPE;
        end else if (b == "[") begin
          mode_q  = MODE_CSI;
          p1_q    = '0;
          p2_q    = '0;
          semis_q = '0;
        end else if (b == "O") begin
          mode_q = MODE_SS3;
        end else begin
          mode_q       = MODE_IDLE;
          hit          = 1'b1;
          r.key        = KEY_CHAR;
          r.code_point = {13'd0, b};
          r.alt_mod    = 1'b1;
        end
      end
      MODE_CSI: begin
        if (w.op) begin
          mode_q = MODE_IDLE;
          hit    = 1'b1;
          r.key  = KEY_ESCAPE;
        end else if (b >= "0" && b <= "9") begin
          // Digits of the third and later parameters are dropped.
          if (semis_q == 2'd0) begin
            acc  = int'(p1_q) * 10 + int'(b - "0");
            p1_q = (acc > 255) ? 8'd255 : acc[7:0];
          end else if (semis_q == 2'd1) begin
            acc  = int'(p2_q) * 10 + int'(b - "0");
            p2_q = acc[2:0];
          end
        end else if (b == ";") begin
          if (semis_q != 2'd2) semis_q = semis_q + 2'd1;
        end else begin
          mode_q = MODE_IDLE;
          hit    = 1'b1;
          if (semis_q != 2'd0) begin
            mods        = p2_q - 3'd1;
            r.shift_mod = mods[0];
            r.alt_mod   = mods[1];
            r.ctrl_mod  = mods[2];
          end
          if (b == "Z") begin
            r.key       = KEY_TAB;
            r.shift_mod = 1'b1;
          end else if (b == "~") begin
            r.key = tilde_key_of(p1_q);
          end else begin
            r.key = cursor_key_of(b);
          end
        end
      end
      MODE_SS3: begin
        mode_q = MODE_IDLE;
        hit    = 1'b1;
        r.key  = w.op ? KEY_ESCAPE : ss3_final_key(b);
      end
      default: begin
        mode_q = MODE_IDLE;
        if (!w.op) begin
          if (b == BYTE_ESC) begin
            mode_q = MODE_ESC;
          end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            lead_q = b;
            mode_q = MODE_UTF8;
            if (b[7:5] == 3'b110) begin
              cp_q   = {16'd0, b[4:0]};
              left_q = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
              cp_q   = {17'd0, b[3:0]};
              left_q = 2'd2;
            end else begin
              cp_q   = {18'd0, b[2:0]};
              left_q = 2'd3;
            end
          end else begin
            hit = 1'b1;
            if (b == 8'd13 || b == 8'd10) begin
              r.key = KEY_ENTER;
            end else if (b == 8'd9) begin
              r.key = KEY_TAB;
            end else if (b == 8'd127 || b == 8'd8) begin
              r.key = KEY_BACKSPACE;
            end else if (b >= 8'd1 && b <= 8'd26) begin
              r.key        = KEY_CHAR;
              r.code_point = 21'("a") + 21'(b) - 21'd1;
              r.ctrl_mod   = 1'b1;
            end else begin
              // Plain ASCII and stray or invalid UTF-8 lead bytes.
              r.key        = KEY_CHAR;
              r.code_point = {13'd0, b};
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  = MODE_IDLE;
      left_q  = '0;
      cp_q    = '0;
      lead_q  = '0;
      p1_q    = '0;
      p2_q    = '0;
      semis_q = '0;
      keys_due.delete();
      pending_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (keys_due.size() == 0) begin
          report_mismatch($sformatf("key word %0d with none pending", key_i.key));
        end else begin
          want = keys_due.pop_front();
          if (key_i.key != want.key)
            report_mismatch($sformatf("key %0d, expected %0d", key_i.key, want.key));
          if (key_i.code_point != want.code_point)
            report_mismatch($sformatf("code_point %0h, expected %0h",
                                      key_i.code_point, want.code_point));
          if (key_i.ctrl_mod != want.ctrl_mod)
            report_mismatch($sformatf("ctrl_mod %0b, expected %0b",
                                      key_i.ctrl_mod, want.ctrl_mod));
          if (key_i.alt_mod != want.alt_mod)
            report_mismatch($sformatf("alt_mod %0b, expected %0b",
                                      key_i.alt_mod, want.alt_mod));
          if (key_i.shift_mod != want.shift_mod)
            report_mismatch($sformatf("shift_mod %0b, expected %0b",
                                      key_i.shift_mod, want.shift_mod));
        end
      end
      if (push_i && !full_i) begin
        decode_word(word_i, made_one, made);
        if (made_one) keys_due.push_back(made);
      end
      pending_o = keys_due.size();
    end
  end

endmodule

// ----- tb/tb_terminal_key_sequence_decoder.sv -----
// Testbench top for the terminal key sequence decoder: byte stream stimulus and verdict.
`timescale 1ns / 1ps

module tb_terminal_key_sequence_decoder;
  import tksd_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  tksd_in_t  in_word = '0;
  logic      full;
  logic      empty;
  tksd_out_t out_word;

  int        fails;
  int        pending;
  int        bytes_sent = 0;
  bit        send_burst = 1'b0;
  bit        take_burst = 1'b0;

  always #1 clk_i = ~clk_i;

  terminal_key_sequence_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_word_i  (in_word),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  tksd_key_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .word_i       (in_word),
    .empty_i      (empty),
    .pop_i        (pop),
    .key_i        (out_word),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Takes result words with random stalls and occasional stretches of none.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 79) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 13);
      @(negedge clk_i);
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop = 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  task automatic send_word(input logic op, input logic [7:0] b, input bit counted);
    int gap;
    if ($urandom_range(0, 79) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push              = 1'b1;
    in_word.op        = op;
    in_word.data_byte = b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (counted) bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b, 1'b1);
  endtask

  task automatic send_timeout();
    send_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_csi(input string body);
    send_byte(BYTE_ESC);
    send_byte("[");
    send_text(body);
  endtask

  task automatic send_ss3(input string body);
    send_byte(BYTE_ESC);
    send_byte("O");
    send_text(body);
  endtask

  task automatic send_digits();
    // Mostly small numbers that hit the known tilde and modifier codes.
    case ($urandom_range(0, 3))
      0: ;
      1, 2: send_text($sformatf("%0d", $urandom_range(0, 30)));
      default: send_text($sformatf("%0d", $urandom_range(0, 99999)));
    endcase
  endtask

  task automatic send_utf8(input bit broken);
    int         len;
    int         good;
    logic [7:0] lead;
    logic [7:0] brk;
    len  = $urandom_range(2, 4);
    lead = 8'($urandom_range(0, 255));
    case (len)
      2: lead[7:5] = 3'b110;
      3: lead[7:4] = 4'b1110;
      default: lead[7:3] = 5'b11110;
    endcase
    good = broken ? int'($urandom_range(0, len - 2)) : len - 1;
    send_byte(lead);
    for (int i = 0; i < good; i++) send_byte({2'b10, 6'($urandom_range(0, 63))});
    if (broken) begin
      if ($urandom_range(0, 2) == 0) begin
        send_timeout();
      end else begin
        // The breaking byte is never a continuation byte.
        brk = 8'($urandom_range(0, 191));
        if (brk[7]) brk[6] = 1'b1;
        send_byte(brk);
      end
    end
  endtask

  task automatic send_random_csi();
    string finals;
    int    pick;
    finals = "ABCDHFZ~~~";
    send_byte(BYTE_ESC);
    send_byte("[");
    send_digits();
    if ($urandom_range(0, 1)) begin
      send_byte(";");
      send_digits();
      if ($urandom_range(0, 3) == 0) begin
        send_byte(";");
        send_digits();
        if ($urandom_range(0, 1)) send_text(";7");
      end
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) send_timeout();
    else if (pick < 5) send_byte(8'($urandom_range(0, 255)));
    else send_byte(finals[$urandom_range(0, finals.len() - 1)]);
  endtask

  task automatic send_random_sequence();
    string ss3_finals;
    int    kind;
    ss3_finals = "PQRSHFABCD";
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      send_byte(8'($urandom_range(0, 127)));
    end else if (kind < 35) begin
      send_utf8(1'b0);
    end else if (kind < 42) begin
      send_utf8(1'b1);
    end else if (kind < 47) begin
      send_byte(BYTE_ESC);
      send_timeout();
    end else if (kind < 55) begin
      send_byte(BYTE_ESC);
      send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 80) begin
      send_random_csi();
    end else if (kind < 90) begin
      send_byte(BYTE_ESC);
      send_byte("O");
      case ($urandom_range(0, 5))
        0: send_timeout();
        1: send_byte(8'($urandom_range(0, 255)));
        default: send_byte(ss3_finals[$urandom_range(0, ss3_finals.len() - 1)]);
      endcase
    end else if (kind < 95) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      // Mostly falls on an idle decoder, so it does not count as work.
      send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: control bytes, UTF-8 edge cases and each escape form.
    send_timeout();
    send_text("\r\n\t");
    send_byte(8'd127);
    send_byte(8'd8);
    send_byte(8'd1);
    send_byte(8'd26);
    send_byte(8'd0);
    send_byte(8'h7E);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hF8);
    send_text("\303\251\342\202\254\364\217\277\277\360\237\230\200");
    send_text("\303A");
    send_text("\342\202");
    send_timeout();
    send_byte(BYTE_ESC);
    send_timeout();
    send_byte(BYTE_ESC);
    send_byte("x");
    send_byte(BYTE_ESC);
    send_byte(8'hFF);
    send_csi("A");
    send_csi("1;5C");
    send_csi("Z");
    send_csi("3~");
    send_csi("999~");
    send_csi("2;3;7~");
    send_csi("1;9H");
    send_csi("24~");
    send_csi(";;;q");
    send_csi("1;");
    send_timeout();
    send_ss3("P");
    send_ss3("D");
    send_ss3("x");
    send_byte(BYTE_ESC);
    send_byte("O");
    send_timeout();

    while (bytes_sent < 1420) send_random_sequence();

    @(negedge clk_i);
    push = 1'b0;
    while (pending != 0) @(negedge clk_i);
    // Waits so that any stray word still in the queues shows up.
    repeat (10) @(negedge clk_i);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
